// ----- design/mss_pkg.sv -----
package mss_pkg;

    localparam int STEPS = 16;
    localparam int IDX_W = $clog2(STEPS);
    localparam int CNT_W = $clog2(STEPS + 1);

    localparam logic signed [7:0] BASE_NONE = -8'sd1;
    localparam logic signed [9:0] NOTE_MAX  = 10'sd127;

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_NOTE  = 3'd1,
        KIND_SKIP  = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_BASE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        GATE_OFF  = 2'd0,
        GATE_ON   = 2'd1,
        GATE_RISE = 2'd2,
        GATE_FALL = 2'd3
    } gate_state_t;

endpackage

// ----- design/mss_if.sv -----
interface mss_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       gate_in;
    logic [6:0] note_in;
    logic [6:0] velocity_in;

    modport source (output valid, kind, gate_in, note_in, velocity_in, input ready);
    modport sink   (input valid, kind, gate_in, note_in, velocity_in, output ready);
endinterface

interface mss_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] step_index;
    logic [4:0] step_count;
    logic       skip_flag;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
    logic       gate_out;
    logic [1:0] gate_state;

    modport source (output valid, step_index, step_count, skip_flag, note_out, velocity_out,
                    gate_out, gate_state, input ready);
    modport sink   (input valid, step_index, step_count, skip_flag, note_out, velocity_out,
                    gate_out, gate_state, output ready);
endinterface

// ----- design/midi_step_sequencer.sv -----
// The input register captures each item on its transfer; the item moves into the result
// register once that register is empty or its result is taken, and waits while it stalls.
// Throughput: one item per cycle unless the result stalls; pattern state and the 16-entry step
// store update in the same cycle the item enters the result register; it reads the new state.
// Reset clears the step count, position, both base notes and the gate history; the step store
// itself is not cleared, and entries above the step count are never shown.
module midi_step_sequencer
    import mss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mss_in_if.sink     item,
    mss_out_if.source  result
);

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [2:0] s1_kind_reg;
    logic       s1_gate_reg;
    logic [6:0] s1_note_reg;
    logic [6:0] s1_vel_reg;

    // pattern state
    logic              gate_store_reg [STEPS];
    logic [6:0]        note_store_reg [STEPS];
    logic [6:0]        vel_store_reg  [STEPS];
    logic [6:0]        last_note_reg;
    logic [6:0]        last_vel_reg;
    logic [CNT_W-1:0]  count_reg,       count_next;
    logic [IDX_W-1:0]  position_reg,    position_next;
    logic signed [7:0] record_base_reg, record_base_next;
    logic signed [7:0] play_base_reg,   play_base_next;
    logic              gate_now_reg,    gate_now_next;
    logic              gate_before_reg, gate_before_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        step_index_reg;
    logic [4:0]        step_count_reg;
    logic              skip_reg;
    logic [6:0]        note_out_reg;
    logic [6:0]        vel_out_reg;
    logic              gate_out_reg;
    gate_state_t       gate_state_reg;

    logic              adv;
    logic              wr_en;
    logic              wr_gate;
    logic [6:0]        wr_note;
    logic [6:0]        wr_vel;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  pos_inc;
    logic              rd_gate;
    logic [6:0]        rd_note;
    logic [6:0]        rd_vel;
    logic              have;
    logic              gated;
    logic signed [9:0] transposed;
    logic [6:0]        note_clamped;
    logic              skip_next;
    logic [6:0]        note_out_next;
    logic [6:0]        vel_out_next;
    logic              gate_out_next;
    gate_state_t       gate_state_next;

    assign adv           = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready    = !s1_valid_reg || adv;
    assign s1_valid_next = (item.valid && item.ready) || (s1_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !result.ready);

    assign wr_idx  = count_reg[IDX_W-1:0];
    assign pos_inc = CNT_W'(position_reg) + CNT_W'(1);

    always_comb
    begin
        count_next       = count_reg;
        position_next    = position_reg;
        record_base_next = record_base_reg;
        play_base_next   = play_base_reg;
        gate_now_next    = gate_now_reg;
        gate_before_next = gate_before_reg;
        wr_en            = 1'b0;
        wr_gate          = 1'b0;
        wr_note          = '0;
        wr_vel           = '0;
        case (kind_t'(s1_kind_reg))
            KIND_TICK:
            begin
                gate_before_next = gate_now_reg;
                gate_now_next    = s1_gate_reg;
                // advance on a rising gate, wrap at the step count
                if (!gate_now_reg && s1_gate_reg)
                begin
                    if (count_reg <= pos_inc)
                        position_next = '0;
                    else
                        position_next = pos_inc[IDX_W-1:0];
                end
            end
            KIND_NOTE:
            begin
                if (count_reg < CNT_W'(STEPS))
                begin
                    wr_en      = 1'b1;
                    wr_gate    = 1'b1;
                    wr_note    = s1_note_reg;
                    wr_vel     = s1_vel_reg;
                    count_next = count_reg + CNT_W'(1);
                    if (record_base_reg == BASE_NONE)
                    begin
                        record_base_next = $signed({1'b0, s1_note_reg});
                        play_base_next   = $signed({1'b0, s1_note_reg});
                    end
                end
            end
            KIND_SKIP:
            begin
                if (count_reg < CNT_W'(STEPS))
                begin
                    wr_en      = 1'b1;
                    wr_gate    = 1'b0;
                    // copy the previous step; the first step gets zeros
                    wr_note    = (count_reg != '0) ? last_note_reg : '0;
                    wr_vel     = (count_reg != '0) ? last_vel_reg  : '0;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_CLEAR:
            begin
                count_next       = '0;
                position_next    = '0;
                record_base_next = BASE_NONE;
                play_base_next   = BASE_NONE;
            end
            KIND_BASE:
            begin
                play_base_next = $signed({1'b0, s1_note_reg});
            end
            default:
            begin
            end
        endcase
    end

    // read the current step after the update, forwarding a same-cycle write
    always_comb
    begin
        if (wr_en && (wr_idx == position_next))
        begin
            rd_gate = wr_gate;
            rd_note = wr_note;
            rd_vel  = wr_vel;
        end
        else
        begin
            rd_gate = gate_store_reg[position_next];
            rd_note = note_store_reg[position_next];
            rd_vel  = vel_store_reg[position_next];
        end
    end

    assign have  = count_next != '0;
    assign gated = have && rd_gate;

    assign transposed = $signed({3'b000, rd_note})
                      + 10'(play_base_next)
                      - 10'(record_base_next);

    always_comb
    begin
        if (transposed < 10'sd0)
            note_clamped = '0;
        else if (transposed > NOTE_MAX)
            note_clamped = 7'(NOTE_MAX);
        else
            note_clamped = transposed[6:0];
    end

    assign skip_next     = have && !rd_gate;
    assign note_out_next = have ? note_clamped : '0;
    assign vel_out_next  = have ? rd_vel : '0;
    assign gate_out_next = gated && gate_now_next;

    always_comb
    begin
        if (have && !gated)
            gate_state_next = GATE_OFF;
        else if (gate_before_next == gate_now_next)
            gate_state_next = gate_now_next ? GATE_ON : GATE_OFF;
        else
            gate_state_next = gate_now_next ? GATE_RISE : GATE_FALL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            count_reg       <= '0;
            position_reg    <= '0;
            record_base_reg <= BASE_NONE;
            play_base_reg   <= BASE_NONE;
            gate_now_reg    <= 1'b0;
            gate_before_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                count_reg       <= count_next;
                position_reg    <= position_next;
                record_base_reg <= record_base_next;
                play_base_reg   <= play_base_next;
                gate_now_reg    <= gate_now_next;
                gate_before_reg <= gate_before_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_kind_reg <= item.kind;
            s1_gate_reg <= item.gate_in;
            s1_note_reg <= item.note_in;
            s1_vel_reg  <= item.velocity_in;
        end
        if (adv && wr_en)
        begin
            gate_store_reg[wr_idx] <= wr_gate;
            note_store_reg[wr_idx] <= wr_note;
            vel_store_reg[wr_idx]  <= wr_vel;
            last_note_reg          <= wr_note;
            last_vel_reg           <= wr_vel;
        end
        if (adv)
        begin
            step_index_reg <= 4'(position_next);
            step_count_reg <= 5'(count_next);
            skip_reg       <= skip_next;
            note_out_reg   <= note_out_next;
            vel_out_reg    <= vel_out_next;
            gate_out_reg   <= gate_out_next;
            gate_state_reg <= gate_state_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.step_index   = step_index_reg;
    assign result.step_count   = step_count_reg;
    assign result.skip_flag    = skip_reg;
    assign result.note_out     = note_out_reg;
    assign result.velocity_out = vel_out_reg;
    assign result.gate_out     = gate_out_reg;
    assign result.gate_state   = gate_state_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STEPS))
        else $error("step count above pattern length");

    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && position_reg == '0) || (CNT_W'(position_reg) < count_reg))
        else $error("position outside recorded steps");

    a_gate_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && gate_out_reg) |-> (!skip_reg && step_count_reg != '0))
        else $error("gate out on a skip step or empty pattern");

    a_base_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && kind_t'(s1_kind_reg) == KIND_CLEAR) |=>
            (record_base_reg == BASE_NONE && play_base_reg == BASE_NONE && count_reg == '0))
        else $error("clear did not reset the pattern");
`endif

endmodule
